[rtl/core/psfa_pkg.sv]
// Shared types and constants for the particle sensor frame alert block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package psfa_pkg;

   localparam logic [7:0]  HDR_FIRST    = 8'h42;
   localparam logic [7:0]  HDR_SECOND   = 8'h4D;
   localparam logic [4:0]  SUM_BYTES    = 5'd28;
   localparam logic [4:0]  LAST_BODY    = 5'd29;
   localparam logic [15:0] FINE_RESET   = 16'd50;
   localparam logic [15:0] COARSE_RESET = 16'd80;

   // CSR indexes
   localparam logic CSR_FINE_LIMIT   = 1'b0;
   localparam logic CSR_COARSE_LIMIT = 1'b1;

   typedef struct packed {
      logic [15:0] pm1_value;
      logic [15:0] pm25_value;
      logic [15:0] pm10_value;
      logic        checksum_good;
      logic        air_alert;
   } result_type;

endpackage

[rtl/core/psfa_parser.sv]
// Frame hunt, checksum and value capture; builds the result on the last body byte.
// Depends on psfa_pkg.
`timescale 1ns / 1ps

module psfa_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 byte_accept,
   input  logic [7:0]           rx_byte,
   input  logic [15:0]          fine_limit,
   input  logic [15:0]          coarse_limit,
   output logic                 result_valid,
   output psfa_pkg::result_type result
);
   import psfa_pkg::*;

   localparam logic [1:0] PH_HUNT   = 2'd0;
   localparam logic [1:0] PH_SECOND = 2'd1;
   localparam logic [1:0] PH_BODY   = 2'd2;

   logic [1:0]  phase_ff, phase_in;
   logic [4:0]  count_ff, count_in;
   logic [15:0] sum_ff, sum_in;
   logic [15:0] pm1_ff, pm1_in;
   logic [15:0] pm25_ff, pm25_in;
   logic [15:0] pm10_ff, pm10_in;
   logic [7:0]  chk_hi_ff, chk_hi_in;

   logic        last_byte;
   logic        good;
   logic [15:0] recv_sum;
   logic [15:0] p1, p25, p10;

   always_comb begin
      phase_in  = phase_ff;
      count_in  = count_ff;
      sum_in    = sum_ff;
      pm1_in    = pm1_ff;
      pm25_in   = pm25_ff;
      pm10_in   = pm10_ff;
      chk_hi_in = chk_hi_ff;
      last_byte = 1'b0;
      if (byte_accept) begin
         case (phase_ff)
            PH_HUNT: begin
               if (rx_byte == HDR_FIRST) phase_in = PH_SECOND;
            end
            PH_SECOND: begin
               if (rx_byte == HDR_SECOND) begin
                  phase_in = PH_BODY;
                  count_in = '0;
                  sum_in   = {8'h00, HDR_FIRST} + {8'h00, HDR_SECOND};
               end else if (rx_byte != HDR_FIRST) begin
                  phase_in = PH_HUNT;
               end
            end
            PH_BODY: begin
               if (count_ff < SUM_BYTES) sum_in = sum_ff + {8'h00, rx_byte};
               case (count_ff)
                  5'd10:   pm1_in  = {rx_byte, 8'h00};
                  5'd11:   pm1_in  = {pm1_ff[15:8], rx_byte};
                  5'd12:   pm25_in = {rx_byte, 8'h00};
                  5'd13:   pm25_in = {pm25_ff[15:8], rx_byte};
                  5'd14:   pm10_in = {rx_byte, 8'h00};
                  5'd15:   pm10_in = {pm10_ff[15:8], rx_byte};
                  5'd28:   chk_hi_in = rx_byte;
                  default: ;
               endcase
               if (count_ff == LAST_BODY) begin
                  last_byte = 1'b1;
                  phase_in  = PH_HUNT;
                  count_in  = '0;
               end else begin
                  count_in = count_ff + 5'd1;
               end
            end
            default: phase_in = PH_HUNT;
         endcase
      end
   end

   // result from held values and the low checksum byte in flight
   assign recv_sum = {chk_hi_ff, rx_byte};
   assign good     = (recv_sum == sum_ff);
   assign p1       = good ? pm1_ff  : 16'h0000;
   assign p25      = good ? pm25_ff : 16'h0000;
   assign p10      = good ? pm10_ff : 16'h0000;

   assign result_valid         = last_byte;
   assign result.pm1_value     = p1;
   assign result.pm25_value    = p25;
   assign result.pm10_value    = p10;
   assign result.checksum_good = good;
   assign result.air_alert     = (p25 > fine_limit) || (p10 > coarse_limit);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         count_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
      end
      sum_ff    <= sum_in;
      pm1_ff    <= pm1_in;
      pm25_ff   <= pm25_in;
      pm10_ff   <= pm10_in;
      chk_hi_ff <= chk_hi_in;
   end

endmodule

[rtl/core/psfa_out_buf.sv]
// Two-entry result buffer: output register plus skid entry.
// Depends on psfa_pkg.
`timescale 1ns / 1ps

module psfa_out_buf (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  psfa_pkg::result_type push_data,
   output logic                 full,
   output logic                 out_valid,
   input  logic                 out_stall,
   output psfa_pkg::result_type out_data
);
   import psfa_pkg::*;

   logic       main_valid_ff, main_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type main_ff, main_in;
   result_type skid_ff, skid_in;
   logic       pop;

   assign pop = main_valid_ff && !out_stall;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff || pop) begin
            main_in       = push_data;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = push_data;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign full      = skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

   a_skid_needs_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid entry held without output entry");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !skid_valid_ff)
      else $error("result pushed into full buffer");

   a_skid_moves_up: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !out_stall) |=> (main_valid_ff && main_ff == $past(skid_ff)))
      else $error("skid entry lost or reordered");

endmodule

[rtl/core/particle_sensor_frame_alert.sv]
// Top level of the particle sensor frame alert block.
// Depends on psfa_pkg, psfa_parser and psfa_out_buf.
`timescale 1ns / 1ps

// Usage:
//  - req_ channel: one received serial byte per beat (req_rx_byte). A beat
//    is taken at a clock edge with req_valid high and req_stall low.
//  - The parser hunts for the header 0x42 0x4D, then takes 30 body bytes.
//    The byte that closes a frame yields one rsp_ beat: the three PM values,
//    checksum_good and air_alert. A bad checksum zeroes the values.
//  - Throughput: one byte per cycle while req_stall is low, set by the byte
//    counter and 16-bit checksum adder in the parser.
//  - Result: formed combinationally from the last body byte, then registered
//    in the output register, or in the skid entry while that one is held.
//  - rsp_stall: results queue in a two-entry buffer (output register and
//    skid entry). Input keeps flowing while one result waits; req_stall is
//    raised only while both entries are occupied.
//  - csr_: write-only. Index 0 is the PM2.5 limit, index 1 the PM10 limit.
//    The limits in place when the last body byte arrives are used.
//  - Reset (synchronous, active high): parser back to the header hunt,
//    buffer emptied, limits to 50 and 80.

module particle_sensor_frame_alert (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_pm1_value,
   output logic [15:0] rsp_pm25_value,
   output logic [15:0] rsp_pm10_value,
   output logic        rsp_checksum_good,
   output logic        rsp_air_alert,
   input  logic        csr_write_en,
   input  logic        csr_index,
   input  logic [15:0] csr_write_data
);
   import psfa_pkg::*;

   logic [15:0] fine_limit_ff;
   logic [15:0] coarse_limit_ff;
   logic        byte_accept;
   logic        res_valid;
   result_type  res_data;
   result_type  out_data;
   logic        buf_full;

   // limit registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fine_limit_ff   <= FINE_RESET;
         coarse_limit_ff <= COARSE_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_FINE_LIMIT:   fine_limit_ff   <= csr_write_data;
            CSR_COARSE_LIMIT: coarse_limit_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign req_stall   = buf_full;
   assign byte_accept = req_valid && !buf_full;

   psfa_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .byte_accept  (byte_accept),
      .rx_byte      (req_rx_byte),
      .fine_limit   (fine_limit_ff),
      .coarse_limit (coarse_limit_ff),
      .result_valid (res_valid),
      .result       (res_data)
   );

   psfa_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res_data),
      .full      (buf_full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (out_data)
   );

   assign rsp_pm1_value     = out_data.pm1_value;
   assign rsp_pm25_value    = out_data.pm25_value;
   assign rsp_pm10_value    = out_data.pm10_value;
   assign rsp_checksum_good = out_data.checksum_good;
   assign rsp_air_alert     = out_data.air_alert;

endmodule

[tb/sv/particle_sensor_frame_alert_test.sv]
// Testbench for particle_sensor_frame_alert: frame hunt, checksum, PM capture and dust alert.
// A queue-fed byte driver, a stalling result monitor and a built-in frame predictor.
// Depends on psfa_pkg and the particle_sensor_frame_alert RTL.
`timescale 1ns / 1ps

module particle_sensor_frame_alert_test;
   import psfa_pkg::*;

   // body offsets of the big-endian concentrations
   localparam logic [4:0] PM1_HI  = 5'd10;
   localparam logic [4:0] PM1_LO  = 5'd11;
   localparam logic [4:0] PM25_HI = 5'd12;
   localparam logic [4:0] PM25_LO = 5'd13;
   localparam logic [4:0] PM10_HI = 5'd14;
   localparam logic [4:0] PM10_LO = 5'd15;
   localparam int         FRAME_LEN   = 32;   // header plus 30 body bytes
   localparam int         PHASE_BYTES = 150;

   typedef enum logic [1:0] {SEEK_FIRST, SEEK_SECOND, IN_BODY} frame_phase_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_pm1_value;
   logic [15:0] rsp_pm25_value;
   logic [15:0] rsp_pm10_value;
   logic        rsp_checksum_good;
   logic        rsp_air_alert;
   logic        csr_write_en = 1'b0;
   logic        csr_index = CSR_FINE_LIMIT;
   logic [15:0] csr_write_data = 16'h0000;

   particle_sensor_frame_alert u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_pm1_value     (rsp_pm1_value),
      .rsp_pm25_value    (rsp_pm25_value),
      .rsp_pm10_value    (rsp_pm10_value),
      .rsp_checksum_good (rsp_checksum_good),
      .rsp_air_alert     (rsp_air_alert),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   // ---------------------------------------------------------------
   // Frame predictor state: our own copy of the parser and the limits
   // ---------------------------------------------------------------
   frame_phase_type frame_phase = SEEK_FIRST;
   logic [4:0]   body_pos    = '0;
   logic [15:0]  sum_acc     = '0;
   logic [15:0]  pm1_acc     = '0;
   logic [15:0]  pm25_acc    = '0;
   logic [15:0]  pm10_acc    = '0;
   logic [7:0]   ck_high     = '0;
   logic [15:0]  fine_lim    = FINE_RESET;
   logic [15:0]  coarse_lim  = COARSE_RESET;

   result_type   pending_results [$];   // frame results still owed by the block
   logic [7:0]   rx_bytes_q [$];        // bytes waiting for the driver
   logic [7:0]   frame_buf [FRAME_LEN];
   logic [7:0]   carry_q [$];           // tail of a frame split across a limit change
   int           err_count   = 0;
   int           bytes_made  = 0;

   initial begin
      forever #10 clock = ~clock;
   end

   // Step the predictor by one accepted byte; a closing body byte queues a result.
   task automatic parse_rx_byte(input logic [7:0] b);
      result_type  r;
      logic [15:0] recv;
      case (frame_phase)
         SEEK_FIRST: begin
            if (b == HDR_FIRST) frame_phase = SEEK_SECOND;
         end
         SEEK_SECOND: begin
            if (b == HDR_SECOND) begin
               frame_phase = IN_BODY;
               body_pos    = '0;
               sum_acc     = 16'(HDR_FIRST) + 16'(HDR_SECOND);
            end else if (b != HDR_FIRST) begin
               // a repeated first byte keeps waiting; anything else restarts
               frame_phase = SEEK_FIRST;
            end
         end
         default: begin
            if (body_pos < SUM_BYTES) sum_acc = sum_acc + 16'(b);
            case (body_pos)
               PM1_HI:    pm1_acc  = {b, 8'h00};
               PM1_LO:    pm1_acc  = pm1_acc | 16'(b);
               PM25_HI:   pm25_acc = {b, 8'h00};
               PM25_LO:   pm25_acc = pm25_acc | 16'(b);
               PM10_HI:   pm10_acc = {b, 8'h00};
               PM10_LO:   pm10_acc = pm10_acc | 16'(b);
               SUM_BYTES: ck_high  = b;
               default: ;
            endcase
            if (body_pos == LAST_BODY) begin
               recv            = {ck_high, b};
               r.checksum_good = (recv == sum_acc);
               // bad checksum zeroes the values, which also kills the alert
               r.pm1_value     = r.checksum_good ? pm1_acc  : 16'h0000;
               r.pm25_value    = r.checksum_good ? pm25_acc : 16'h0000;
               r.pm10_value    = r.checksum_good ? pm10_acc : 16'h0000;
               r.air_alert     = (r.pm25_value > fine_lim) || (r.pm10_value > coarse_lim);
               pending_results.push_back(r);
               frame_phase = SEEK_FIRST;
               body_pos    = '0;
            end else begin
               body_pos = body_pos + 5'd1;
            end
         end
      endcase
   endtask

   // ---------------------------------------------------------------
   // Driver: bursts of beats with random gaps, stalled beat is held
   // ---------------------------------------------------------------
   int burst_left = 0;
   int gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) parse_rx_byte(req_rx_byte);
         if (!(req_valid && req_stall)) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (rx_bytes_q.size() > 0) begin
               req_valid   <= 1'b1;
               req_rx_byte <= rx_bytes_q.pop_front();
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 40);
                  // about a quarter of bursts run straight into the next one
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Monitor: checks each result beat, stalls in runs of its own
   // ---------------------------------------------------------------
   int stall_hold = 0;

   task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         err_count++;
      end
   endtask

   always @(posedge clock) begin
      result_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               $display("%0t: result beat with none expected, actual %0h/%0h/%0h good=%0b alert=%0b",
                        $time, rsp_pm1_value, rsp_pm25_value, rsp_pm10_value,
                        rsp_checksum_good, rsp_air_alert);
               err_count++;
            end else begin
               want = pending_results.pop_front();
               check_field("pm1_value", want.pm1_value, rsp_pm1_value);
               check_field("pm25_value", want.pm25_value, rsp_pm25_value);
               check_field("pm10_value", want.pm10_value, rsp_pm10_value);
               check_field("checksum_good", 16'(want.checksum_good), 16'(rsp_checksum_good));
               check_field("air_alert", 16'(want.air_alert), 16'(rsp_air_alert));
            end
         end
         if (stall_hold > 0) begin
            stall_hold--;
         end else if (rsp_stall) begin
            rsp_stall  <= 1'b0;
            stall_hold = ($urandom_range(0, 9) < 3) ? $urandom_range(20, 60) : $urandom_range(0, 8);
         end else begin
            rsp_stall  <= 1'b1;
            // long stalls fill both output entries and push back on the input
            stall_hold = ($urandom_range(0, 9) < 2) ? $urandom_range(10, 40) : $urandom_range(0, 4);
         end
      end
   end

   // ---------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------
   task automatic push_byte(input logic [7:0] b);
      rx_bytes_q.push_back(b);
      bytes_made++;
   endtask

   // Build one frame into frame_buf, optionally with a corrupted checksum.
   task automatic make_frame(input logic [15:0] v1, input logic [15:0] v25,
                             input logic [15:0] v10, input bit bad_sum);
      logic [15:0] sum;
      int          k;
      frame_buf[0] = HDR_FIRST;
      frame_buf[1] = HDR_SECOND;
      for (int i = 2; i < FRAME_LEN - 2; i++) frame_buf[i] = 8'($urandom_range(0, 255));
      frame_buf[2 + PM1_HI]  = v1[15:8];
      frame_buf[2 + PM1_LO]  = v1[7:0];
      frame_buf[2 + PM25_HI] = v25[15:8];
      frame_buf[2 + PM25_LO] = v25[7:0];
      frame_buf[2 + PM10_HI] = v10[15:8];
      frame_buf[2 + PM10_LO] = v10[7:0];
      sum = '0;
      for (int i = 0; i < FRAME_LEN - 2; i++) sum = sum + 16'(frame_buf[i]);
      if (bad_sum) begin
         k      = $urandom_range(0, 15);
         sum[k] = ~sum[k];
      end
      frame_buf[FRAME_LEN - 2] = sum[15:8];
      frame_buf[FRAME_LEN - 1] = sum[7:0];
   endtask

   task automatic push_frame(input logic [15:0] v1, input logic [15:0] v25,
                             input logic [15:0] v10, input bit bad_sum);
      make_frame(v1, v25, v10, bad_sum);
      for (int i = 0; i < FRAME_LEN; i++) push_byte(frame_buf[i]);
   endtask

   // Noise leans on header bytes to exercise the hunt.
   task automatic push_noise(input int n);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 7))
            0, 1:    push_byte(HDR_FIRST);
            2:       push_byte(HDR_SECOND);
            default: push_byte(8'($urandom_range(0, 255)));
         endcase
      end
   endtask

   function automatic logic [15:0] pick_value(input logic [15:0] lim);
      case ($urandom_range(0, 6))
         0:       return lim;
         1:       return (lim == 16'hFFFF) ? lim : lim + 16'd1;
         2:       return (lim == 16'h0000) ? lim : lim - 16'd1;
         3:       return 16'h0000;
         4:       return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic write_limit(input logic idx, input logic [15:0] val);
      @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= val;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      if (idx == CSR_FINE_LIMIT) fine_lim = val;
      else coarse_lim = val;
   endtask

   // Wait until every byte is taken and every result seen, then let the
   // parser settle (the result is registered behind the last byte).
   task automatic wait_drained();
      while (rx_bytes_q.size() != 0 || req_valid || pending_results.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // ---------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------
   logic [15:0] fine_set   [7];
   logic [15:0] coarse_set [7];

   initial begin
      int cut;
      int phase_start;
      fine_set   = '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'($urandom), 16'($urandom),
                     FINE_RESET};
      coarse_set = '{16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'($urandom), 16'($urandom),
                     COARSE_RESET};

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: hunt corner cases, then frames at the value and limit extremes.
      push_byte(8'h00);
      push_byte(8'hFF);
      push_byte(HDR_SECOND);          // second header byte alone is ignored
      push_byte(HDR_FIRST);
      push_byte(8'h00);               // broken header goes back to hunting
      push_byte(HDR_FIRST);
      push_byte(HDR_FIRST);           // repeated first byte, frame header follows
      push_frame(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
      push_frame(16'h0001, FINE_RESET, COARSE_RESET, 1'b0);       // at the limits: quiet
      push_frame(16'h0000, FINE_RESET + 16'd1, 16'h0000, 1'b0);   // fine limit trips
      push_frame(16'h0000, 16'h0000, COARSE_RESET + 16'd1, 1'b0); // coarse limit trips
      push_frame(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);             // bad checksum zeroes all
      wait_drained();

      // Random: one limit setting per phase, mostly well-formed frames.
      for (int p = 0; p < 7; p++) begin
         write_limit(CSR_FINE_LIMIT, fine_set[p]);
         write_limit(CSR_COARSE_LIMIT, coarse_set[p]);
         // finish a frame that was started under the previous setting
         while (carry_q.size() > 0) push_byte(carry_q.pop_front());
         phase_start = bytes_made;
         while (bytes_made - phase_start < PHASE_BYTES) begin
            case ($urandom_range(0, 9))
               0: push_noise($urandom_range(1, 6));
               1: begin
                  // truncated frame: the next bytes get swallowed as body
                  push_byte(HDR_FIRST);
                  push_byte(HDR_SECOND);
                  push_noise($urandom_range(1, 29));
               end
               default: push_frame(pick_value(16'($urandom)), pick_value(fine_lim),
                                   pick_value(coarse_lim), $urandom_range(0, 5) == 0);
            endcase
         end
         // leave a good frame half sent across the next limit change
         make_frame(16'($urandom), pick_value(fine_set[(p + 1) % 7]),
                    pick_value(coarse_set[(p + 1) % 7]), 1'b0);
         cut = $urandom_range(1, FRAME_LEN - 1);
         for (int i = 0; i < FRAME_LEN; i++) begin
            if (i < cut) push_byte(frame_buf[i]);
            else carry_q.push_back(frame_buf[i]);
         end
         wait_drained();
      end
      while (carry_q.size() > 0) push_byte(carry_q.pop_front());
      wait_drained();
      repeat (10) @(posedge clock);

      if (err_count == 0 && pending_results.size() == 0) begin
         $display("particle_sensor_frame_alert_test OK");
      end else begin
         $display("particle_sensor_frame_alert_test NOT OK");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #10_000_000;
      $display("particle_sensor_frame_alert_test NOT OK");
      $finish;
   end

endmodule
